>>> hdl/sbvr_pkg.sv
// ----------------------------------------------------------------------------
// sbvr_pkg
// Shared types and constants of the spherical basis vector rotation core.
// ----------------------------------------------------------------------------
package sbvr_pkg;

  localparam int COMP_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;

  // Quarter-wave sine datapath.
  localparam int ACC_W     = 33;   // Horner accumulator, signed Q2.30
  localparam int U_W       = 17;   // position in the quadrant, 0..65536
  localparam int SINE_W    = 15;   // quarter-wave sine, unsigned Q1.14
  localparam int TRIG_W    = 16;   // signed sine or cosine, Q1.14
  localparam int ENTRY_W   = 31;   // signed frame entry, Q28
  localparam int QS_STAGES = 6;    // register stages of the quarter-wave sine
  localparam int FRAC_SHIFT = 28;  // Q28 entry times Q2.13 down to Q2.13

  localparam logic signed [ACC_W-1:0] POLY_C9 = 33'sd172272;
  localparam logic signed [ACC_W-1:0] HORNER_C [4] = '{
    33'sd5026995, 33'sd85569306, 33'sd693598670, 33'sd1686629713
  };
  localparam logic signed [ACC_W-1:0] Q30_ONE = 33'sh040000000;

  // Direction of the transform.
  localparam logic KIND_TO_SPH  = 1'b0;
  localparam logic KIND_TO_CART = 1'b1;

  // Quadrant of an angle.
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  typedef logic signed [ENTRY_W-1:0] entry_t;

endpackage

>>> hdl/sbvr_if.sv
// ----------------------------------------------------------------------------
// sbvr_in_if / sbvr_out_if
// Valid/ready channels carrying the input and result words of the core.
// ----------------------------------------------------------------------------
interface sbvr_in_if #(
  parameter int COMP_BITS  = 16,
  parameter int ANGLE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic signed [COMP_BITS-1:0] comp_a;
  logic signed [COMP_BITS-1:0] comp_b;
  logic signed [COMP_BITS-1:0] comp_c;
  logic [ANGLE_BITS-1:0]       polar_angle;
  logic [ANGLE_BITS-1:0]       azimuth_angle;

  modport source (output valid, kind, comp_a, comp_b, comp_c, polar_angle,
                  azimuth_angle, input ready);
  modport sink (input valid, kind, comp_a, comp_b, comp_c, polar_angle,
                azimuth_angle, output ready);
endinterface

interface sbvr_out_if #(
  parameter int COMP_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [COMP_BITS-1:0] res_a;
  logic signed [COMP_BITS-1:0] res_b;
  logic signed [COMP_BITS-1:0] res_c;

  modport source (output valid, res_a, res_b, res_c, input ready);
  modport sink (input valid, res_a, res_b, res_c, output ready);
endinterface

>>> hdl/sbvr_qsine.sv
// ----------------------------------------------------------------------------
// sbvr_qsine
// Six-stage quarter-wave sine: square, four Horner steps, final scaling.
// ----------------------------------------------------------------------------
module sbvr_qsine (
  input  logic                           clk_i,
  input  logic [sbvr_pkg::QS_STAGES-1:0] en_i,
  input  logic [sbvr_pkg::U_W-1:0]       u_i,
  output logic [sbvr_pkg::SINE_W-1:0]    sine_o
);
  import sbvr_pkg::*;

  logic [2*U_W-1:0]        sq;
  logic [U_W-1:0]          u_q   [5];
  logic [U_W-1:0]          u2_q  [4];
  logic signed [ACC_W-1:0] acc_q [4];

  assign sq = u_i * u_i;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      u_q[0]  <= u_i;
      u2_q[0] <= sq[U_W+15:16];
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_horner
    logic signed [ACC_W-1:0]   acc_in;
    logic signed [ACC_W+U_W:0] prod;

    if (j == 0) begin : g_first
      assign acc_in = POLY_C9;
    end else begin : g_next
      assign acc_in = acc_q[j-1];
    end

    assign prod = acc_in * $signed({1'b0, u2_q[j]});

    always_ff @(posedge clk_i) begin
      if (en_i[j+1]) begin
        acc_q[j] <= HORNER_C[j] - ACC_W'(prod >>> 16);
        u_q[j+1] <= u_q[j];
      end
    end

    if (j < 3) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i[j+1]) begin
          u2_q[j+1] <= u2_q[j];
        end
      end
    end
  end

  logic signed [ACC_W+U_W:0] prod_f;
  logic signed [ACC_W+U_W:0] scaled;
  logic [30:0]               clamped;
  logic [31:0]               rounded;

  assign prod_f = acc_q[3] * $signed({1'b0, u_q[4]});
  assign scaled = prod_f >>> 16;

  always_comb begin
    if (scaled < 0) begin
      clamped = '0;
    end else if (scaled > Q30_ONE) begin
      clamped = 31'(Q30_ONE);
    end else begin
      clamped = scaled[30:0];
    end
    rounded = {1'b0, clamped} + 32'h0000_8000;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      sine_o <= rounded[SINE_W+15:16];
    end
  end

endmodule

>>> hdl/sbvr_frame.sv
// ----------------------------------------------------------------------------
// sbvr_frame
// Folds the quarter-wave sines into sine and cosine of both angles and
// registers the nine entries of the rotation matrix for the chosen direction.
// ----------------------------------------------------------------------------
module sbvr_frame (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        kind_i,
  input  logic [1:0]                  quad_p_i,
  input  logic [1:0]                  quad_a_i,
  input  logic [sbvr_pkg::SINE_W-1:0] sin_p_i,
  input  logic [sbvr_pkg::SINE_W-1:0] cos_p_i,
  input  logic [sbvr_pkg::SINE_W-1:0] sin_a_i,
  input  logic [sbvr_pkg::SINE_W-1:0] cos_a_i,
  output sbvr_pkg::entry_t            m_o [9]
);
  import sbvr_pkg::*;

  logic signed [TRIG_W-1:0] st, ct, sp, cp;
  entry_t stcp, stsp, ctcp, ctsp, st28, ct28, sp28, cp28;
  entry_t m_d [9];

  // Quadrant folding: the pair (a, b) holds S(t) and S(1 - t).
  function automatic void fold(input logic [1:0] quad, input logic [SINE_W-1:0] a,
                               input logic [SINE_W-1:0] b,
                               output logic signed [TRIG_W-1:0] sn,
                               output logic signed [TRIG_W-1:0] cs);
    logic signed [TRIG_W-1:0] sa, sb;
    sa = $signed({1'b0, a});
    sb = $signed({1'b0, b});
    case (quad)
      QUAD_I:   begin sn = sa;  cs = sb;  end
      QUAD_II:  begin sn = sb;  cs = -sa; end
      QUAD_III: begin sn = -sa; cs = -sb; end
      default:  begin sn = -sb; cs = sa;  end
    endcase
  endfunction

  always_comb begin
    fold(quad_p_i, sin_p_i, cos_p_i, st, ct);
    fold(quad_a_i, sin_a_i, cos_a_i, sp, cp);
    stcp = ENTRY_W'(st * cp);
    stsp = ENTRY_W'(st * sp);
    ctcp = ENTRY_W'(ct * cp);
    ctsp = ENTRY_W'(ct * sp);
    st28 = ENTRY_W'(st) <<< 14;
    ct28 = ENTRY_W'(ct) <<< 14;
    sp28 = ENTRY_W'(sp) <<< 14;
    cp28 = ENTRY_W'(cp) <<< 14;
    if (kind_i == KIND_TO_SPH) begin
      m_d[0] = stcp;  m_d[1] = stsp;  m_d[2] = ct28;
      m_d[3] = ctcp;  m_d[4] = ctsp;  m_d[5] = -st28;
      m_d[6] = -sp28; m_d[7] = cp28;  m_d[8] = '0;
    end else begin
      m_d[0] = stcp;  m_d[1] = ctcp;  m_d[2] = -sp28;
      m_d[3] = stsp;  m_d[4] = ctsp;  m_d[5] = cp28;
      m_d[6] = ct28;  m_d[7] = -st28; m_d[8] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_o <= m_d;
    end
  end

endmodule

>>> hdl/spherical_basis_vector_rotation_core.sv
// ----------------------------------------------------------------------------
// spherical_basis_vector_rotation_core
// Rotates a vector between Cartesian axes and the local spherical frame.
// ----------------------------------------------------------------------------
// Usage: input words arrive on in_i (valid/ready) with a direction bit, three
// signed Q2.13 components and the polar and azimuth angles as fractions of a
// full turn. Kind zero projects onto (radial, polar, azimuthal), kind one
// rebuilds (x, y, z). Results leave on out_o (valid/ready), saturated Q2.13.
// The pipeline has nine register stages: six for the quarter-wave sine
// polynomial, one for the frame products, one for the component products and
// one for the sum, rounding and saturation, which is also the output register.
// A result becomes valid on out_o once its word has passed all nine register
// stages; one word is taken every cycle while the
// receiver keeps up.
// Each stage moves when it is empty or when the stage after it moves, so a
// stalled receiver fills the bubbles first and only then holds ready low.
// Reset clears the stage valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module spherical_basis_vector_rotation_core #(
  parameter int COMP_BITS  = sbvr_pkg::COMP_BITS_DEF,
  parameter int ANGLE_BITS = sbvr_pkg::ANGLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbvr_in_if.sink     in_i,
  sbvr_out_if.source  out_o
);
  import sbvr_pkg::*;

  localparam int NST = QS_STAGES + 3;
  localparam int PW  = ENTRY_W + COMP_BITS;
  localparam int SW  = PW + 2;
  localparam int RW  = SW - FRAC_SHIFT;
  localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [RW-1:0] RES_MAX = RW'((64'd1 << (COMP_BITS - 1)) - 64'd1);
  localparam logic signed [RW-1:0] RES_MIN = -RES_MAX - RW'(1);

  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Phase of each angle on a 32-bit full turn.
  logic [31:0]    ph_p, ph_a;
  logic [U_W-1:0] u_ps, u_pc, u_as, u_ac;

  assign ph_p = 32'(in_i.polar_angle) << (32 - ANGLE_BITS);
  assign ph_a = 32'(in_i.azimuth_angle) << (32 - ANGLE_BITS);
  assign u_ps = {1'b0, ph_p[29:14]};
  assign u_pc = 17'h1_0000 - u_ps;
  assign u_as = {1'b0, ph_a[29:14]};
  assign u_ac = 17'h1_0000 - u_as;

  logic [SINE_W-1:0] s_ps, s_pc, s_as, s_ac;

  sbvr_qsine u_qs_ps (.clk_i, .en_i(en[QS_STAGES-1:0]), .u_i(u_ps), .sine_o(s_ps));
  sbvr_qsine u_qs_pc (.clk_i, .en_i(en[QS_STAGES-1:0]), .u_i(u_pc), .sine_o(s_pc));
  sbvr_qsine u_qs_as (.clk_i, .en_i(en[QS_STAGES-1:0]), .u_i(u_as), .sine_o(s_as));
  sbvr_qsine u_qs_ac (.clk_i, .en_i(en[QS_STAGES-1:0]), .u_i(u_ac), .sine_o(s_ac));

  // Side band that travels beside the sine pipeline.
  logic                        kind_q [QS_STAGES];
  logic [1:0]                  qp_q   [QS_STAGES];
  logic [1:0]                  qa_q   [QS_STAGES];
  logic signed [COMP_BITS-1:0] comp_q [QS_STAGES+1][3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= QS_STAGES; k++) begin
      if (en[k]) begin
        if (k == 0) begin
          kind_q[0]    <= in_i.kind;
          qp_q[0]      <= ph_p[31:30];
          qa_q[0]      <= ph_a[31:30];
          comp_q[0][0] <= in_i.comp_a;
          comp_q[0][1] <= in_i.comp_b;
          comp_q[0][2] <= in_i.comp_c;
        end else begin
          if (k < QS_STAGES) begin
            kind_q[k] <= kind_q[k-1];
            qp_q[k]   <= qp_q[k-1];
            qa_q[k]   <= qa_q[k-1];
          end
          comp_q[k] <= comp_q[k-1];
        end
      end
    end
  end

  entry_t m [9];

  sbvr_frame u_frame (
    .clk_i,
    .en_i     (en[QS_STAGES]),
    .kind_i   (kind_q[QS_STAGES-1]),
    .quad_p_i (qp_q[QS_STAGES-1]),
    .quad_a_i (qa_q[QS_STAGES-1]),
    .sin_p_i  (s_ps),
    .cos_p_i  (s_pc),
    .sin_a_i  (s_as),
    .cos_a_i  (s_ac),
    .m_o      (m)
  );

  // Entry times component, one product per matrix entry.
  logic signed [PW-1:0] prod_q [9];

  always_ff @(posedge clk_i) begin
    if (en[QS_STAGES+1]) begin
      for (int i = 0; i < 9; i++) begin
        prod_q[i] <= m[i] * comp_q[QS_STAGES][i % 3];
      end
    end
  end

  // Row sums, rounded half up to Q2.13 and saturated.
  logic signed [COMP_BITS-1:0] res_q [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] biased;
    logic signed [RW-1:0] rnd;
    logic signed [COMP_BITS-1:0] sat;

    always_comb begin
      sum    = SW'(prod_q[3*r]) + SW'(prod_q[3*r+1]) + SW'(prod_q[3*r+2]);
      biased = sum + ROUND_HALF;
      rnd    = RW'(biased >>> FRAC_SHIFT);
      if (rnd > RES_MAX) begin
        sat = COMP_BITS'(RES_MAX);
      end else if (rnd < RES_MIN) begin
        sat = COMP_BITS'(RES_MIN);
      end else begin
        sat = rnd[COMP_BITS-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[NST-1]) begin
        res_q[r] <= sat;
      end
    end
  end

  assign out_o.valid = v_q[NST-1];
  assign out_o.res_a = res_q[0];
  assign out_o.res_b = res_q[1];
  assign out_o.res_c = res_q[2];

  // An empty output register never blocks the input side.
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled while the output register is empty");

  // With the whole pipeline empty no result can appear in the next cycle.
  a_no_invented_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q == '0) |=> !out_o.valid)
    else $error("result word appeared from an empty pipeline");

  // An accepted word always occupies the first stage afterwards.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v_q[0])
    else $error("accepted word lost at the pipeline entry");

endmodule

>>> test/spherical_basis_vector_rotation_core_test.sv
// ----------------------------------------------------------------------------
// spherical_basis_vector_rotation_core_test
// Drives directed and random words through the rotation core and compares
// every result word with a fixed-point predictor of the frame transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module spherical_basis_vector_rotation_core_test;
  import sbvr_pkg::*;

  localparam int CB = 16;
  localparam int AB = 16;
  localparam int N_RANDOM = 1530;

  typedef struct packed {
    logic                 kind;
    logic signed [CB-1:0] comp_a;
    logic signed [CB-1:0] comp_b;
    logic signed [CB-1:0] comp_c;
    logic [AB-1:0]        polar;
    logic [AB-1:0]        azimuth;
  } vec_word_t;

  typedef struct packed {
    logic signed [CB-1:0] res_a;
    logic signed [CB-1:0] res_b;
    logic signed [CB-1:0] res_c;
  } rot_word_t;

  // Quarter-wave sine in Q1.14 for u in 0..65536.
  function automatic longint quarter_wave(longint u);
    longint u2, acc, s;
    u2  = (u * u) >>> 16;
    acc = 172272;
    acc = 5026995 - ((acc * u2) >>> 16);
    acc = 85569306 - ((acc * u2) >>> 16);
    acc = 693598670 - ((acc * u2) >>> 16);
    acc = 1686629713 - ((acc * u2) >>> 16);
    s   = (acc * u) >>> 16;
    if (s < 0) s = 0;
    if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
    return (s + (64'sd1 <<< 15)) >>> 16;
  endfunction

  function automatic void angle_trig(logic [AB-1:0] ang, output longint sn,
                                     output longint cs);
    logic [31:0] ph;
    longint t, a, b;
    ph = {ang, {(32-AB){1'b0}}};
    t  = ph[29:14];
    a  = quarter_wave(t);
    b  = quarter_wave(65536 - t);
    case (ph[31:30])
      QUAD_I:   begin sn = a;  cs = b;  end
      QUAD_II:  begin sn = b;  cs = -a; end
      QUAD_III: begin sn = -a; cs = -b; end
      default:  begin sn = -b; cs = a;  end
    endcase
  endfunction

  // Rounds a Q28-scaled sum to Q2.13, half upwards, then saturates.
  function automatic logic signed [CB-1:0] round_sat(longint v);
    longint r;
    r = (v + (64'sd1 <<< 27)) >>> 28;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[CB-1:0];
  endfunction

  function automatic rot_word_t rotate_vector(vec_word_t w);
    longint st, ct, sp, cp, a, b, c, r0, r1, r2;
    rot_word_t r;
    angle_trig(w.polar, st, ct);
    angle_trig(w.azimuth, sp, cp);
    a = w.comp_a; b = w.comp_b; c = w.comp_c;
    if (w.kind == KIND_TO_SPH) begin
      r0 = st*cp*a + st*sp*b + ct*16384*c;
      r1 = ct*cp*a + ct*sp*b - st*16384*c;
      r2 = -sp*16384*a + cp*16384*b;
    end else begin
      r0 = st*cp*a + ct*cp*b - sp*16384*c;
      r1 = st*sp*a + ct*sp*b + cp*16384*c;
      r2 = ct*16384*a - st*16384*b;
    end
    r.res_a = round_sat(r0);
    r.res_b = round_sat(r1);
    r.res_c = round_sat(r2);
    return r;
  endfunction

  class rotation_scoreboard;
    rot_word_t pending[$];
    int        errors;

    function void note_input(vec_word_t w);
      pending.push_back(rotate_vector(w));
    endfunction

    function void check_result(rot_word_t got);
      rot_word_t want;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.res_a !== want.res_a) begin
        $error("res_a expected %0d actual %0d", want.res_a, got.res_a); errors++;
      end
      if (got.res_b !== want.res_b) begin
        $error("res_b expected %0d actual %0d", want.res_b, got.res_b); errors++;
      end
      if (got.res_c !== want.res_c) begin
        $error("res_c expected %0d actual %0d", want.res_c, got.res_c); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  sbvr_in_if  #(.COMP_BITS(CB), .ANGLE_BITS(AB)) in_ch ();
  sbvr_out_if #(.COMP_BITS(CB)) out_ch ();
  rotation_scoreboard sb = new();
  bit  stimulus_done = 1'b0;
  bit  hold_off_now = 1'b0;
  bit  calm_stretch = 1'b0;
  int  n_accepted = 0;

  spherical_basis_vector_rotation_core #(.COMP_BITS(CB), .ANGLE_BITS(AB)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.kind = 1'b0; in_ch.comp_a = '0; in_ch.comp_b = '0;
    in_ch.comp_c = '0; in_ch.polar_angle = '0; in_ch.azimuth_angle = '0;
    out_ch.ready = 1'b0;
  end

  // Offers one word, idling now and then, and waits for it to be taken.
  task automatic send_word(vec_word_t w);
    while (!calm_stretch && $urandom_range(99) < 24) @(negedge clk_i);
    in_ch.valid = 1'b1; in_ch.kind = w.kind;
    in_ch.comp_a = w.comp_a; in_ch.comp_b = w.comp_b; in_ch.comp_c = w.comp_c;
    in_ch.polar_angle = w.polar; in_ch.azimuth_angle = w.azimuth;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(w);
    n_accepted++;
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic [CB-1:0] pick_comp();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return CB'($urandom_range(200) - 100);
      default: return CB'($urandom());
    endcase
  endfunction

  function automatic logic [AB-1:0] pick_angle();
    case ($urandom_range(5))
      0: return {2'($urandom_range(3)), 14'h0};
      1: return AB'({2'($urandom_range(3)), 14'h0} + $urandom_range(4) - 2);
      default: return AB'($urandom());
    endcase
  endfunction

  initial begin
    vec_word_t w;
    logic [AB-1:0] edges[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff,
                                16'h2000};
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Directed: both kinds, extreme components, quadrant boundaries.
    for (int i = 0; i < 12; i++) begin
      w.kind = i[0] ? KIND_TO_CART : KIND_TO_SPH;
      w.comp_a = i[1] ? 16'sh7fff : 16'sh8000;
      w.comp_b = i[2] ? 16'sh8000 : 16'sh7fff;
      w.comp_c = (i % 3 == 0) ? 16'sh7fff : 16'sh8000;
      w.polar = edges[i % 6];
      w.azimuth = edges[(i + 2) % 6];
      send_word(w);
    end
    for (int i = 0; i < 8; i++) begin
      w.kind = i[0];
      w.comp_a = 16'sd8192; w.comp_b = -16'sd8192; w.comp_c = '0;
      w.polar = AB'(edges[i % 6] + 1); w.azimuth = AB'(edges[(i + 3) % 6] - 1);
      send_word(w);
    end
    // Pause until every result is in.
    wait (sb.pending.size() == 0);
    @(negedge clk_i);
    for (int i = 0; i < N_RANDOM; i++) begin
      calm_stretch = (i >= 300 && i < 500);
      hold_off_now = (i >= 700 && i < 720);
      w.kind = 1'($urandom_range(1));
      w.comp_a = pick_comp(); w.comp_b = pick_comp(); w.comp_c = pick_comp();
      w.polar = pick_angle(); w.azimuth = pick_angle();
      send_word(w);
    end
    calm_stretch = 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off while words keep coming.
  initial begin
    int hold;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_now && hold == 0) hold = 60;
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        hold--;
        if (hold == 0) hold = -1;
      end else begin
        out_ch.ready = calm_stretch ? 1'b1 : ($urandom_range(99) >= 24);
      end
      if (!hold_off_now && hold < 0) hold = 0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.res_a, out_ch.res_b, out_ch.res_c});
  end

  initial begin
    wait (stimulus_done);
    wait (sb.pending.size() == 0);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
hdl/sbvr_pkg.sv
hdl/sbvr_if.sv
hdl/sbvr_qsine.sv
hdl/sbvr_frame.sv
hdl/spherical_basis_vector_rotation_core.sv
test/spherical_basis_vector_rotation_core_test.sv
